>>> rtl/cc20_pkg.sv
`default_nettype none

package cc20_pkg;

    localparam int ROUNDS = 20;

    typedef logic [31:0] word_t;
    typedef word_t [15:0] state_t;

    // one block in flight: counter travels along for the final add
    typedef struct packed {
        logic   vld;
        word_t  ctr;
        state_t st;
    } blk_t;

    typedef struct packed {
        logic       step_en;
        logic       load;
        logic [1:0] sub;
    } cell_ctl_t;

    typedef struct packed {
        logic [63:0] key01;
        logic [63:0] key23;
        logic [63:0] key45;
        logic [63:0] key67;
        logic [63:0] nonce01;
        word_t       nonce2;
    } cfg_t;

    localparam word_t SIGMA0 = 32'h61707865;
    localparam word_t SIGMA1 = 32'h3320646e;
    localparam word_t SIGMA2 = 32'h79622d32;
    localparam word_t SIGMA3 = 32'h6b206574;

    localparam logic [2:0] REG_KEY01   = 3'd0;
    localparam logic [2:0] REG_KEY23   = 3'd1;
    localparam logic [2:0] REG_KEY45   = 3'd2;
    localparam logic [2:0] REG_KEY67   = 3'd3;
    localparam logic [2:0] REG_NONCE01 = 3'd4;
    localparam logic [2:0] REG_NONCE2  = 3'd5;

    localparam logic [3:0] PHASE_LAST = 4'd15;
    localparam logic [1:0] SUB_LAST   = 2'd3;

    function automatic state_t init_state(cfg_t c, word_t ctr);
        state_t s;
        s[0]  = SIGMA0;
        s[1]  = SIGMA1;
        s[2]  = SIGMA2;
        s[3]  = SIGMA3;
        s[4]  = c.key01[31:0];
        s[5]  = c.key01[63:32];
        s[6]  = c.key23[31:0];
        s[7]  = c.key23[63:32];
        s[8]  = c.key45[31:0];
        s[9]  = c.key45[63:32];
        s[10] = c.key67[31:0];
        s[11] = c.key67[63:32];
        s[12] = ctr;
        s[13] = c.nonce01[31:0];
        s[14] = c.nonce01[63:32];
        s[15] = c.nonce2;
        return s;
    endfunction

    // rotate each row of the 4x4 word matrix left by one column
    function automatic state_t rows_left(state_t s);
        state_t r;
        for (int row = 0; row < 4; row++) begin
            for (int col = 0; col < 4; col++) begin
                r[row*4 + col] = s[row*4 + ((col + 1) % 4)];
            end
        end
        return r;
    endfunction

    // row r rotated left by r: diagonals land in columns
    function automatic state_t diag_fwd(state_t s);
        state_t r;
        for (int row = 0; row < 4; row++) begin
            for (int col = 0; col < 4; col++) begin
                r[row*4 + col] = s[row*4 + ((col + row) % 4)];
            end
        end
        return r;
    endfunction

    function automatic state_t diag_inv(state_t s);
        state_t r;
        for (int row = 0; row < 4; row++) begin
            for (int col = 0; col < 4; col++) begin
                r[row*4 + col] = s[row*4 + ((col + 4 - row) % 4)];
            end
        end
        return r;
    endfunction

    // rotate amounts 16, 12, 8, 7 for the four quarter-round steps
    function automatic word_t rotl_step(word_t v, logic [1:0] sub);
        word_t r;
        case (sub)
            2'd0:    r = {v[15:0], v[31:16]};
            2'd1:    r = {v[19:0], v[31:20]};
            2'd2:    r = {v[23:0], v[31:24]};
            default: r = {v[24:0], v[31:25]};
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/cc20_cell.sv
`default_nettype none

// One round of add-xor-rotate steps on column 0, one step per cycle while
// ctl.step_en is high; rows shifted left after each quarter-round.
module cc20_cell
    import cc20_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cell_ctl_t ctl,
    input  wire logic      diag,
    input  wire blk_t      blk_in,
    output blk_t           blk_out
);

    state_t st_reg;
    state_t st_next;
    state_t step_st;
    state_t step_rot;
    word_t  ctr_reg;
    logic   vld_reg;
    word_t  x;
    word_t  y;
    word_t  z;
    word_t  sum;
    word_t  mixed;

    always_comb
    begin
        x     = ctl.sub[0] ? st_reg[8]  : st_reg[0];
        y     = ctl.sub[0] ? st_reg[12] : st_reg[4];
        z     = ctl.sub[0] ? st_reg[4]  : st_reg[12];
        sum   = x + y;
        mixed = rotl_step(z ^ sum, ctl.sub);
        step_st = st_reg;
        if (ctl.sub[0])
        begin
            step_st[8] = sum;
            step_st[4] = mixed;
        end
        else
        begin
            step_st[0]  = sum;
            step_st[12] = mixed;
        end
        step_rot = (ctl.sub == SUB_LAST) ? rows_left(step_st) : step_st;
    end

    always_comb
    begin
        if (ctl.load)
        begin
            st_next = diag ? diag_fwd(blk_in.st) : blk_in.st;
        end
        else
        begin
            st_next = step_rot;
        end
    end

    assign blk_out.vld = vld_reg;
    assign blk_out.ctr = ctr_reg;
    assign blk_out.st  = diag ? diag_inv(step_rot) : step_rot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (ctl.step_en && ctl.load)
        begin
            vld_reg <= blk_in.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.step_en)
        begin
            st_reg <= st_next;
            if (ctl.load)
            begin
                ctr_reg <= blk_in.ctr;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/cc20_ostage.sv
`default_nettype none

// Holds a finished block, adds the initial state and sends one word per beat.
module cc20_ostage
    import cc20_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire logic  take,
    input  wire blk_t  blk,
    output logic       buf_free,
    output logic       out_valid,
    input  wire logic  out_ready,
    output logic [3:0] word_index,
    output word_t      keystream_word,
    output logic       last_word
);

    state_t     buf_reg;
    state_t     buf_next;
    state_t     ini_reg;
    state_t     ini_next;
    logic       buf_vld_reg;
    logic       buf_vld_next;
    logic [3:0] idx_reg;
    logic [3:0] idx_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    word_t      word_reg;
    logic [3:0] oidx_reg;
    logic       last_reg;
    logic       out_load;
    logic       load_blk;

    assign out_load = buf_vld_reg && (!out_valid_reg || out_ready);
    assign buf_free = !buf_vld_reg || (out_load && idx_reg == PHASE_LAST);
    assign load_blk = take && blk.vld;

    always_comb
    begin
        buf_next     = buf_reg;
        ini_next     = ini_reg;
        buf_vld_next = buf_vld_reg;
        idx_next     = idx_reg;
        if (load_blk)
        begin
            buf_next     = blk.st;
            ini_next     = init_state(cfg, blk.ctr);
            buf_vld_next = 1'b1;
            idx_next     = '0;
        end
        else if (out_load)
        begin
            for (int i = 0; i < 15; i++)
            begin
                buf_next[i] = buf_reg[i + 1];
                ini_next[i] = ini_reg[i + 1];
            end
            idx_next = idx_reg + 4'd1;
            if (idx_reg == PHASE_LAST)
            begin
                buf_vld_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_vld_reg   <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            buf_vld_reg   <= buf_vld_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
        ini_reg <= ini_next;
        if (out_load)
        begin
            word_reg <= buf_reg[0] + ini_reg[0];
            oidx_reg <= idx_reg;
            last_reg <= (idx_reg == PHASE_LAST);
        end
    end

    assign out_valid      = out_valid_reg;
    assign word_index     = oidx_reg;
    assign keystream_word = word_reg;
    assign last_word      = last_reg;

endmodule

`default_nettype wire

>>> rtl/chacha20_keystream_block.sv
`default_nettype none

// Channel   | Handshake               | Payload
// ----------+-------------------------+-----------------------------------------
// input     | in_valid / in_ready     | block_counter[31:0]
// output    | out_valid / out_ready   | word_index[3:0], keystream_word, last_word
// config    | APB psel/penable/pwrite | paddr[5:0] (8*i), pwdata/prdata[63:0]
//
// A chain of ROUNDS round cells, each doing one round with one 32-bit adder;
// all cells hand over their block together. The chain takes a new block at
// each hand-over while earlier blocks are still in flight; each block leaves
// as 16 output beats. A full output buffer at the hand-over cycle, while the
// last cell holds a valid block, stalls the whole chain.
// Reset clears valid bits and the phase counter; config registers reset to 0.
module chacha20_keystream_block
    import cc20_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] block_counter,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [3:0]       word_index,
    output logic [31:0]      keystream_word,
    output logic             last_word
);

    cfg_t       cfg_reg;
    logic [2:0] reg_sel;
    logic       cfg_wr;
    logic [3:0] phase_reg;
    logic       step_en;
    logic       boundary;
    logic       buf_free;
    logic       inq_vld_reg;
    word_t      inq_ctr_reg;
    cell_ctl_t  ctl;
    blk_t       chain [ROUNDS+1];

    // ---------------- config port ----------------
    assign reg_sel = paddr[5:3];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (reg_sel)
                REG_KEY01:   cfg_reg.key01   <= pwdata;
                REG_KEY23:   cfg_reg.key23   <= pwdata;
                REG_KEY45:   cfg_reg.key45   <= pwdata;
                REG_KEY67:   cfg_reg.key67   <= pwdata;
                REG_NONCE01: cfg_reg.nonce01 <= pwdata;
                REG_NONCE2:  cfg_reg.nonce2  <= pwdata[31:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_KEY01:   prdata = cfg_reg.key01;
            REG_KEY23:   prdata = cfg_reg.key23;
            REG_KEY45:   prdata = cfg_reg.key45;
            REG_KEY67:   prdata = cfg_reg.key67;
            REG_NONCE01: prdata = cfg_reg.nonce01;
            REG_NONCE2:  prdata = {32'd0, cfg_reg.nonce2};
            default:     prdata = '0;
        endcase
    end

    // ---------------- chain control ----------------
    assign step_en  = !((phase_reg == PHASE_LAST) && chain[ROUNDS].vld && !buf_free);
    assign boundary = step_en && (phase_reg == PHASE_LAST);

    assign ctl.step_en = step_en;
    assign ctl.load    = boundary;
    assign ctl.sub     = phase_reg[1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
        end
        else if (step_en)
        begin
            phase_reg <= phase_reg + 4'd1;
        end
    end

    // one-beat input holding register, drained at each hand-over
    assign in_ready = !inq_vld_reg || boundary;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inq_vld_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            inq_vld_reg <= 1'b1;
        end
        else if (boundary)
        begin
            inq_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            inq_ctr_reg <= block_counter;
        end
    end

    assign chain[0].vld = inq_vld_reg;
    assign chain[0].ctr = inq_ctr_reg;
    assign chain[0].st  = init_state(cfg_reg, inq_ctr_reg);

    // even cells do column rounds, odd cells diagonal rounds
    for (genvar k = 0; k < ROUNDS; k++)
    begin : g_cell
        cc20_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl),
            .diag    ((k % 2) == 1),
            .blk_in  (chain[k]),
            .blk_out (chain[k+1])
        );
    end

    cc20_ostage u_ostage (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .take           (boundary),
        .blk            (chain[ROUNDS]),
        .buf_free       (buf_free),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .word_index     (word_index),
        .keystream_word (keystream_word),
        .last_word      (last_word)
    );

endmodule

`default_nettype wire

>>> tb/sv/chacha20_keystream_block_test.sv
`timescale 1ns / 1ps

module chacha20_keystream_block_test
    import cc20_pkg::*;
();

    // indexes past the register file: writes there must change nothing
    localparam logic [2:0] REG_SPARE6 = 3'd6;
    localparam logic [2:0] REG_SPARE7 = 3'd7;

    localparam int NUM_REGS     = 6;
    localparam int PLAN_ROWS    = 24;
    localparam int PHASES       = 6;
    localparam int PHASE_BLOCKS = 70;
    localparam int CALM_PHASE   = 3;
    localparam int DRAIN_CYCLES = 16 * (ROUNDS + 1) + 32;

    typedef enum logic {ROW_CFG, ROW_BLK} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [2:0]  reg_idx;
        logic [63:0] value;
        word_t       ctr;
    } plan_row_t;

    typedef struct packed {
        logic [3:0] idx;
        word_t      word;
        logic       last;
    } ks_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [31:0] block_counter = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [3:0]  word_index;
    logic [31:0] keystream_word;
    logic        last_word;

    logic [63:0] cfg_shadow [NUM_REGS];
    ks_beat_t    keystream_q [$];
    ks_beat_t    head_beat;
    int          mismatches = 0;
    bit          calm = 1'b0;

    plan_row_t plan [PLAN_ROWS] = '{
        '{ROW_BLK, REG_KEY01,   64'd0,                  32'h0000_0000},
        '{ROW_BLK, REG_KEY01,   64'd0,                  32'hffff_ffff},
        '{ROW_CFG, REG_KEY01,   64'hffff_ffff_ffff_ffff, 32'h0},
        '{ROW_CFG, REG_KEY23,   64'hffff_ffff_ffff_ffff, 32'h0},
        '{ROW_CFG, REG_KEY45,   64'hffff_ffff_ffff_ffff, 32'h0},
        '{ROW_CFG, REG_KEY67,   64'hffff_ffff_ffff_ffff, 32'h0},
        '{ROW_CFG, REG_NONCE01, 64'hffff_ffff_ffff_ffff, 32'h0},
        '{ROW_CFG, REG_NONCE2,  64'hffff_ffff_ffff_ffff, 32'h0},
        '{ROW_BLK, REG_KEY01,   64'd0,                  32'h0000_0000},
        '{ROW_BLK, REG_KEY01,   64'd0,                  32'hffff_ffff},
        '{ROW_CFG, REG_SPARE6,  64'd0,                  32'h0},
        '{ROW_CFG, REG_SPARE7,  64'd0,                  32'h0},
        '{ROW_BLK, REG_KEY01,   64'd0,                  32'h0000_0001},
        '{ROW_CFG, REG_KEY01,   64'h0706_0504_0302_0100, 32'h0},
        '{ROW_CFG, REG_KEY23,   64'h0f0e_0d0c_0b0a_0908, 32'h0},
        '{ROW_CFG, REG_KEY45,   64'h1716_1514_1312_1110, 32'h0},
        '{ROW_CFG, REG_KEY67,   64'h1f1e_1d1c_1b1a_1918, 32'h0},
        '{ROW_CFG, REG_NONCE01, 64'h4a00_0000_0900_0000, 32'h0},
        '{ROW_CFG, REG_NONCE2,  64'hffff_ffff_0000_0000, 32'h0},
        '{ROW_BLK, REG_KEY01,   64'd0,                  32'h0000_0001},
        '{ROW_BLK, REG_KEY01,   64'd0,                  32'h8000_0000},
        '{ROW_BLK, REG_KEY01,   64'd0,                  32'h7fff_ffff},
        '{ROW_BLK, REG_KEY01,   64'd0,                  32'ha5a5_a5a5},
        '{ROW_BLK, REG_KEY01,   64'd0,                  32'h5a5a_5a5a}
    };

    chacha20_keystream_block u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .block_counter  (block_counter),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .word_index     (word_index),
        .keystream_word (keystream_word),
        .last_word      (last_word)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [127:0] quarter_mix(word_t a, word_t b, word_t c, word_t d);
        a = a + b; d = d ^ a; d = {d[15:0], d[31:16]};
        c = c + d; b = b ^ c; b = {b[19:0], b[31:20]};
        a = a + b; d = d ^ a; d = {d[23:0], d[31:24]};
        c = c + d; b = b ^ c; b = {b[24:0], b[31:25]};
        return {a, b, c, d};
    endfunction

    function automatic state_t chacha_keystream(word_t ctr);
        state_t       init;
        state_t       w;
        logic [127:0] q;
        int           ib;
        int           ic;
        int           id;
        init[0] = 32'h6170_7865;
        init[1] = 32'h3320_646e;
        init[2] = 32'h7962_2d32;
        init[3] = 32'h6b20_6574;
        for (int k = 0; k < 4; k++)
        begin
            init[4 + 2*k] = cfg_shadow[k][31:0];
            init[5 + 2*k] = cfg_shadow[k][63:32];
        end
        init[12] = ctr;
        init[13] = cfg_shadow[REG_NONCE01][31:0];
        init[14] = cfg_shadow[REG_NONCE01][63:32];
        init[15] = cfg_shadow[REG_NONCE2][31:0];
        w = init;
        for (int r = 0; r < ROUNDS; r++)
        begin
            for (int qi = 0; qi < 4; qi++)
            begin
                // even rounds work on columns, odd rounds on diagonals
                if (r % 2 == 0)
                begin
                    ib = 4 + qi;
                    ic = 8 + qi;
                    id = 12 + qi;
                end
                else
                begin
                    ib = 4 + (qi + 1) % 4;
                    ic = 8 + (qi + 2) % 4;
                    id = 12 + (qi + 3) % 4;
                end
                q = quarter_mix(w[qi], w[ib], w[ic], w[id]);
                w[qi] = q[127:96];
                w[ib] = q[95:64];
                w[ic] = q[63:32];
                w[id] = q[31:0];
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            w[i] = w[i] + init[i];
        end
        return w;
    endfunction

    task automatic queue_block(word_t ctr);
        state_t ks;
        ks = chacha_keystream(ctr);
        for (int i = 0; i < 16; i++)
        begin
            keystream_q.push_back(ks_beat_t'{idx: 4'(i), word: ks[i],
                                             last: (4'(i) == PHASE_LAST)});
        end
    endtask

    // entered and left at a falling edge
    task automatic send_block(word_t ctr);
        while (!calm && $urandom_range(99) < 31)
        begin
            in_valid = 1'b0;
            block_counter = $urandom;
            @(negedge clk);
        end
        in_valid = 1'b1;
        block_counter = ctr;
        do @(posedge clk); while (!in_ready);
        queue_block(ctr);
        @(negedge clk);
    endtask

    task automatic cfg_write(logic [2:0] reg_idx, logic [63:0] value);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {reg_idx, 3'b000};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        if (reg_idx == REG_NONCE2)
            cfg_shadow[reg_idx] = {32'd0, value[31:0]};
        else if (reg_idx < REG_NONCE2)
            cfg_shadow[reg_idx] = value;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic wait_idle();
        while (keystream_q.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        out_ready = calm || ($urandom_range(99) >= 31);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (keystream_q.size() == 0)
            begin
                $display("%0t: unexpected beat, word_index %0d keystream_word %08h last_word %0b",
                         $time, word_index, keystream_word, last_word);
                mismatches++;
            end
            else
            begin
                head_beat = keystream_q.pop_front();
                if (word_index !== head_beat.idx)
                begin
                    $display("%0t: word_index expected %0d, got %0d",
                             $time, head_beat.idx, word_index);
                    mismatches++;
                end
                if (keystream_word !== head_beat.word)
                begin
                    $display("%0t: keystream_word[%0d] expected %08h, got %08h",
                             $time, head_beat.idx, head_beat.word, keystream_word);
                    mismatches++;
                end
                if (last_word !== head_beat.last)
                begin
                    $display("%0t: last_word[%0d] expected %0b, got %0b",
                             $time, head_beat.idx, head_beat.last, last_word);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        #(5_000_000);
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        logic [63:0] value;
        word_t       ctr;
        word_t       prev_ctr;
        for (int i = 0; i < NUM_REGS; i++)
        begin
            cfg_shadow[i] = '0;
        end
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (plan[k])
        begin
            if (plan[k].kind == ROW_CFG)
            begin
                in_valid = 1'b0;
                wait_idle();
                cfg_write(plan[k].reg_idx, plan[k].value);
            end
            else
            begin
                send_block(plan[k].ctr);
            end
        end
        in_valid = 1'b0;

        prev_ctr = '0;
        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            // first two phases pin the key and nonce at all-zero and all-one
            for (int ri = 0; ri <= REG_SPARE7; ri++)
            begin
                if (ri >= NUM_REGS)
                    value = {$urandom, $urandom};
                else if (p == 0)
                    value = '0;
                else if (p == 1)
                    value = '1;
                else
                    value = {$urandom, $urandom};
                cfg_write(3'(ri), value);
            end
            calm = (p == CALM_PHASE);
            for (int n = 0; n < PHASE_BLOCKS; n++)
            begin
                case ($urandom_range(3))
                    0:       ctr = prev_ctr + 1;
                    1:       ctr = $urandom_range(1) ? 32'hffff_ffff : 32'h0;
                    default: ctr = $urandom;
                endcase
                send_block(ctr);
                prev_ctr = ctr;
            end
            in_valid = 1'b0;
            calm = 1'b0;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> chacha20_keystream_block.f
rtl/cc20_pkg.sv
rtl/cc20_cell.sv
rtl/cc20_ostage.sv
rtl/chacha20_keystream_block.sv
tb/sv/chacha20_keystream_block_test.sv
